// File: hw/rtl/sft_pkg.sv
package sft_pkg;

   localparam int PLANE_COUNT_DEF = 6;
   localparam int COORD_WIDTH_DEF = 32;

   localparam int AXIS_COUNT = 3;
   localparam int INDEX_W    = 3;
   localparam int NORMAL_W   = 18;
   localparam int FIELD_W    = 32;
   localparam int RADIUS_W   = 31;
   localparam int FRAC_SHIFT = 16;

   localparam int REQ_DATA_W = INDEX_W + AXIS_COUNT * NORMAL_W + 2 * AXIS_COUNT * FIELD_W
                               + RADIUS_W;
   localparam int RSP_DATA_W = 8;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   // first member sits in the highest bits
   typedef struct packed {
      logic [RADIUS_W-1:0]        radius;
      logic signed [FIELD_W-1:0]  center_z;
      logic signed [FIELD_W-1:0]  center_y;
      logic signed [FIELD_W-1:0]  center_x;
      logic signed [FIELD_W-1:0]  anchor_z;
      logic signed [FIELD_W-1:0]  anchor_y;
      logic signed [FIELD_W-1:0]  anchor_x;
      logic signed [NORMAL_W-1:0] normal_z;
      logic signed [NORMAL_W-1:0] normal_y;
      logic signed [NORMAL_W-1:0] normal_x;
      logic [INDEX_W-1:0]         plane_index;
   } req_data_type;

endpackage

// File: hw/rtl/sphere_frustum_test_unit.sv
// Sphere against frustum planes test, four register stages.
// A test item's result is registered in stages 1, 2, 3 and 4 before rsp_tvalid.
// Throughput: one test item per cycle while rsp_tready does not stall; a load item
// blocks new items until it has written its plane on leaving stage 2.
// Reset: synchronous, clears the pipeline valids and all planes to zero.
module sphere_frustum_test_unit #(
   parameter int PLANE_COUNT = sft_pkg::PLANE_COUNT_DEF,
   parameter int COORD_WIDTH = sft_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // plane_index, normal_x/y/z, anchor_x/y/z, center_x/y/z, radius
   input  logic [sft_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // inside_res, zero padding
   output logic [sft_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int NW     = sft_pkg::NORMAL_W;
   localparam int AX     = sft_pkg::AXIS_COUNT;
   localparam int PROD_W = NW + COORD_WIDTH;
   localparam int SUM_W  = PROD_W + 2;
   localparam int DIST_W = SUM_W + 1;
   localparam int RSC_W  = sft_pkg::RADIUS_W + sft_pkg::FRAC_SHIFT + 1;
   localparam int CMP_W  = (DIST_W > RSC_W) ? DIST_W : RSC_W;

   sft_pkg::req_data_type req_data;
   logic                  req_accept;
   logic                  en1, en2, en3, en4, hazard, load_wr;

   // plane store
   logic signed [NW-1:0]    nrm_ff [PLANE_COUNT][AX];
   logic signed [SUM_W-1:0] off_ff [PLANE_COUNT];

   // stage 1: captured item
   logic                            v1_ff, cmd1_ff;
   logic [sft_pkg::INDEX_W-1:0]     idx1_ff;
   logic signed [NW-1:0]            nrm1_ff [AX];
   logic signed [COORD_WIDTH-1:0]   crd1_ff [AX];
   logic [sft_pkg::RADIUS_W-1:0]    rad1_ff;
   logic signed [COORD_WIDTH-1:0]   crd1_in [AX];

   // stage 2: products
   logic                            v2_ff, cmd2_ff;
   logic [sft_pkg::INDEX_W-1:0]     idx2_ff;
   logic signed [NW-1:0]            nrm2_ff [AX];
   logic signed [PROD_W-1:0]        prd2_ff [PLANE_COUNT][AX];
   logic signed [PROD_W-1:0]        ldp2_ff [AX];
   logic signed [SUM_W-1:0]         off2_ff [PLANE_COUNT];
   logic [sft_pkg::RADIUS_W-1:0]    rad2_ff;
   logic signed [SUM_W-1:0]         ldsum;

   // stage 3: distances
   logic                            v3_ff;
   logic signed [DIST_W-1:0]        dist3_ff [PLANE_COUNT];
   logic signed [DIST_W-1:0]        dist3_in [PLANE_COUNT];
   logic [sft_pkg::RADIUS_W-1:0]    rad3_ff;

   // stage 4: result
   logic                            v4_ff, inside4_ff, inside4_in;
   logic signed [CMP_W-1:0]         rad_cmp;

   assign req_data = sft_pkg::req_data_type'(req_tdata);

   assign en4    = !v4_ff || rsp_tready;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign hazard = (v1_ff && cmd1_ff == sft_pkg::CMD_LOAD) ||
                   (v2_ff && cmd2_ff == sft_pkg::CMD_LOAD);
   assign req_tready = en1 && !hazard;
   assign req_accept = req_tvalid && req_tready;
   assign load_wr    = v2_ff && cmd2_ff == sft_pkg::CMD_LOAD && en3;

   always_comb begin
      if (req_tuser[0] == sft_pkg::CMD_LOAD) begin
         crd1_in[0] = req_data.anchor_x[COORD_WIDTH-1:0];
         crd1_in[1] = req_data.anchor_y[COORD_WIDTH-1:0];
         crd1_in[2] = req_data.anchor_z[COORD_WIDTH-1:0];
      end else begin
         crd1_in[0] = req_data.center_x[COORD_WIDTH-1:0];
         crd1_in[1] = req_data.center_y[COORD_WIDTH-1:0];
         crd1_in[2] = req_data.center_z[COORD_WIDTH-1:0];
      end
   end

   always_comb begin
      ldsum = SUM_W'(ldp2_ff[0]) + SUM_W'(ldp2_ff[1]) + SUM_W'(ldp2_ff[2]);
      for (int p = 0; p < PLANE_COUNT; p++) begin
         dist3_in[p] = DIST_W'(prd2_ff[p][0]) + DIST_W'(prd2_ff[p][1])
                     + DIST_W'(prd2_ff[p][2]) - DIST_W'(off2_ff[p]);
      end
   end

   always_comb begin
      rad_cmp    = $signed(CMP_W'({rad3_ff, sft_pkg::FRAC_SHIFT'(0)}));
      inside4_in = 1'b1;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         if (!(CMP_W'(dist3_ff[p]) < rad_cmp)) begin
            inside4_in = 1'b0;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_accept;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff && cmd2_ff == sft_pkg::CMD_TEST;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // plane store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PLANE_COUNT; p++) begin
            off_ff[p] <= '0;
            for (int k = 0; k < AX; k++) begin
               nrm_ff[p][k] <= '0;
            end
         end
      end else begin
         for (int p = 0; p < PLANE_COUNT; p++) begin
            if (load_wr && idx2_ff == sft_pkg::INDEX_W'(p)) begin
               off_ff[p] <= ldsum;
               for (int k = 0; k < AX; k++) begin
                  nrm_ff[p][k] <= nrm2_ff[k];
               end
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (en1 && req_accept) begin
         cmd1_ff    <= req_tuser[0];
         idx1_ff    <= req_data.plane_index;
         nrm1_ff[0] <= req_data.normal_x;
         nrm1_ff[1] <= req_data.normal_y;
         nrm1_ff[2] <= req_data.normal_z;
         crd1_ff    <= crd1_in;
         rad1_ff    <= req_data.radius;
      end
      if (en2) begin
         cmd2_ff <= cmd1_ff;
         idx2_ff <= idx1_ff;
         nrm2_ff <= nrm1_ff;
         rad2_ff <= rad1_ff;
         for (int k = 0; k < AX; k++) begin
            ldp2_ff[k] <= nrm1_ff[k] * crd1_ff[k];
         end
         for (int p = 0; p < PLANE_COUNT; p++) begin
            off2_ff[p] <= off_ff[p];
            for (int k = 0; k < AX; k++) begin
               prd2_ff[p][k] <= nrm_ff[p][k] * crd1_ff[k];
            end
         end
      end
      if (en3) begin
         dist3_ff <= dist3_in;
         rad3_ff  <= rad2_ff;
      end
      if (en4) begin
         inside4_ff <= inside4_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {(sft_pkg::RSP_DATA_W - 1)'(0), inside4_ff};

`ifndef NO_ASSERTIONS
   // a test never reads the store while an older load is still pending
   assert property (@(posedge clock) disable iff (reset)
      !(v1_ff && cmd1_ff == sft_pkg::CMD_TEST && v2_ff && cmd2_ff == sft_pkg::CMD_LOAD))
      else $error("test overtook a pending plane load");

   // store only changes through a load leaving stage 2
   assert property (@(posedge clock) disable iff (reset)
      !$stable(off_ff[0]) |-> ($past(reset) || $past(load_wr)))
      else $error("plane offset changed without a load");

   assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !v1_ff && !v2_ff && !v3_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

// File: tb/tb_sphere_frustum_test_unit.sv
`timescale 1ns / 1ps

module tb_sphere_frustum_test_unit;

   localparam int PLANES       = sft_pkg::PLANE_COUNT_DEF;
   localparam int AXES         = sft_pkg::AXIS_COUNT;
   localparam int RANDOM_ITEMS = 1700;
   localparam int CALM_TAIL    = 200;
   localparam int ONE          = 65536;
   localparam int COORD_MAX    = 32'h7fff_ffff;
   localparam int COORD_MIN    = 32'h8000_0000;
   localparam int NORMAL_MAX   = 131071;
   localparam int NORMAL_MIN   = -131072;

   typedef struct {
      logic                  cmd;
      sft_pkg::req_data_type data;
      logic                  typed;
      logic                  want;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   sft_pkg::req_data_type          req_tdata;
   logic [0:0]                     req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [sft_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // plane store of the predictor
   logic signed [sft_pkg::NORMAL_W-1:0] plane_nrm [PLANES][AXES];
   longint                              plane_ofs [PLANES];

   logic inside_due[$];
   logic typed_known;
   logic typed_inside;
   bit   idling_on = 1'b1;
   int   errors;
   int   counted;

   sphere_frustum_test_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic longint wide18(input logic [sft_pkg::NORMAL_W-1:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint wide32(input logic [sft_pkg::FIELD_W-1:0] v);
      return longint'($signed(v));
   endfunction

   function automatic void plane_write(input sft_pkg::req_data_type d);
      int slot;
      if (d.plane_index >= PLANES) return;
      slot = d.plane_index;
      plane_nrm[slot][0] = d.normal_x;
      plane_nrm[slot][1] = d.normal_y;
      plane_nrm[slot][2] = d.normal_z;
      plane_ofs[slot] = wide18(d.normal_x) * wide32(d.anchor_x)
                      + wide18(d.normal_y) * wide32(d.anchor_y)
                      + wide18(d.normal_z) * wide32(d.anchor_z);
   endfunction

   function automatic logic sphere_inside(input sft_pkg::req_data_type d);
      longint reach;
      longint gap;
      logic   verdict;
      reach = longint'({33'd0, d.radius}) * ONE;
      verdict = 1'b1;
      for (int p = 0; p < PLANES; p++) begin
         gap = wide18(plane_nrm[p][0]) * wide32(d.center_x)
             + wide18(plane_nrm[p][1]) * wide32(d.center_y)
             + wide18(plane_nrm[p][2]) * wide32(d.center_z) - plane_ofs[p];
         if (!(gap < reach)) verdict = 1'b0;
      end
      return verdict;
   endfunction

   // every field random; the fields an item does not use stay as noise
   function automatic sft_pkg::req_data_type noise_item();
      sft_pkg::req_data_type d;
      d.plane_index = sft_pkg::INDEX_W'($urandom);
      d.normal_x    = sft_pkg::NORMAL_W'($urandom);
      d.normal_y    = sft_pkg::NORMAL_W'($urandom);
      d.normal_z    = sft_pkg::NORMAL_W'($urandom);
      d.anchor_x    = $urandom;
      d.anchor_y    = $urandom;
      d.anchor_z    = $urandom;
      d.center_x    = $urandom;
      d.center_y    = $urandom;
      d.center_z    = $urandom;
      d.radius      = sft_pkg::RADIUS_W'($urandom);
      return d;
   endfunction

   function automatic sft_pkg::req_data_type load_item(input int slot, input int nx,
                                                       input int ny, input int nz,
                                                       input int ax, input int ay,
                                                       input int az);
      sft_pkg::req_data_type d;
      d = noise_item();
      d.plane_index = sft_pkg::INDEX_W'(slot);
      d.normal_x = sft_pkg::NORMAL_W'(nx);
      d.normal_y = sft_pkg::NORMAL_W'(ny);
      d.normal_z = sft_pkg::NORMAL_W'(nz);
      d.anchor_x = ax;
      d.anchor_y = ay;
      d.anchor_z = az;
      return d;
   endfunction

   function automatic sft_pkg::req_data_type test_item(input int cx, input int cy,
                                                       input int cz,
                                                       input logic [sft_pkg::RADIUS_W-1:0] r);
      sft_pkg::req_data_type d;
      d = noise_item();
      d.center_x = cx;
      d.center_y = cy;
      d.center_z = cz;
      d.radius   = r;
      return d;
   endfunction

   // axis-aligned box face: slot k faces +/- along axis k/2
   function automatic sft_pkg::req_data_type box_item(input int k, input int half);
      int n[AXES];
      int a[AXES];
      int s;
      s = (k % 2) ? -1 : 1;
      for (int i = 0; i < AXES; i++) begin
         n[i] = 0;
         a[i] = $urandom;
      end
      n[k / 2] = s * ONE;
      a[k / 2] = s * half;
      return load_item(k, n[0], n[1], n[2], a[0], a[1], a[2]);
   endfunction

   function automatic int spread(input int span);
      return $urandom_range(0, 4 * span * ONE) - 2 * span * ONE;
   endfunction

   task automatic push_item(input logic cmd, input sft_pkg::req_data_type d,
                            input logic known, input logic want);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      typed_known  = known;
      typed_inside = want;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!(cmd == sft_pkg::CMD_LOAD && d.plane_index >= PLANES)) counted++;
      @(negedge clock);
   endtask

   task automatic run_scene();
      int kind;
      int half;
      int span;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         half = $urandom_range(1, 200);
         span = half;
         for (int k = 0; k < PLANES; k++)
            if ($urandom_range(0, 9) != 0)
               push_item(sft_pkg::CMD_LOAD,
                         box_item(k, half * ONE + $urandom_range(0, ONE - 1)),
                         1'b0, 1'b0);
      end else if (kind < 9) begin
         span = 256;
         for (int k = 0; k < PLANES; k++)
            push_item(sft_pkg::CMD_LOAD, load_item(k, $urandom_range(0, 2 * ONE) - ONE,
                                                   $urandom_range(0, 2 * ONE) - ONE,
                                                   $urandom_range(0, 2 * ONE) - ONE,
                                                   spread(64), spread(64), spread(64)),
                      1'b0, 1'b0);
      end else begin
         span = 256;
         repeat ($urandom_range(1, 8)) push_item(sft_pkg::CMD_LOAD, noise_item(), 1'b0, 1'b0);
      end
      repeat ($urandom_range(10, 60)) begin
         if ($urandom_range(0, 29) == 0)
            push_item(sft_pkg::CMD_LOAD, noise_item(), 1'b0, 1'b0);
         else if ($urandom_range(0, 9) == 0)
            push_item(sft_pkg::CMD_TEST, noise_item(), 1'b0, 1'b0);
         else
            push_item(sft_pkg::CMD_TEST, test_item(spread(span), spread(span), spread(span),
                                                   $urandom_range(0, 64 * ONE)), 1'b0, 1'b0);
      end
   endtask

   always @(posedge clock) begin : watch
      logic due;
      if (reset) begin
         for (int p = 0; p < PLANES; p++) begin
            for (int i = 0; i < AXES; i++) plane_nrm[p][i] = '0;
            plane_ofs[p] = 0;
         end
         inside_due.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == sft_pkg::CMD_LOAD)
               plane_write(req_tdata);
            else
               inside_due.push_back(typed_known ? typed_inside : sphere_inside(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (inside_due.size() == 0) begin
               $error("inside_res: expected nothing, actual %0b", rsp_tdata[0]);
               errors++;
            end else begin
               due = inside_due.pop_front();
               if (rsp_tdata[0] !== due) begin
                  $error("inside_res: expected %0b, actual %0b", due, rsp_tdata[0]);
                  errors++;
               end
            end
         end
      end
   end

   initial begin : sink
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : source
      stim_row_type directed_rows[$];
      errors       = 0;
      counted      = 0;
      typed_known  = 1'b0;
      typed_inside = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;

      // untouched planes give zero distance: inside only for a non-zero radius
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(0, 0, 0, 31'd0), 1'b1, 1'b0});
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(0, 0, 0, 31'd1), 1'b1, 1'b1});
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(COORD_MAX, COORD_MAX, COORD_MAX,
                                                             31'h7fff_ffff), 1'b1, 1'b1});
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(COORD_MIN, COORD_MIN, COORD_MIN,
                                                             31'd0), 1'b1, 1'b0});
      // slots past the last plane are dropped
      directed_rows.push_back('{sft_pkg::CMD_LOAD, load_item(7, ONE, ONE, ONE, COORD_MAX,
                                                             COORD_MAX, COORD_MAX),
                                1'b0, 1'b0});
      directed_rows.push_back('{sft_pkg::CMD_LOAD, load_item(6, -ONE, -ONE, -ONE, COORD_MIN,
                                                             COORD_MIN, COORD_MIN),
                                1'b0, 1'b0});
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(0, 0, 0, 31'd1), 1'b1, 1'b1});
      for (int k = 0; k < PLANES; k++)
         directed_rows.push_back('{sft_pkg::CMD_LOAD, box_item(k, 10 * ONE), 1'b0, 1'b0});
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(0, 0, 0, 31'd0), 1'b0, 1'b0});
      // on the face: distance equals radius, so strictly-below fails
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(10 * ONE, 0, 0, 31'd0),
                                1'b0, 1'b0});
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(10 * ONE, 0, 0, 31'd1),
                                1'b0, 1'b0});
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(0, 0, -11 * ONE, ONE),
                                1'b0, 1'b0});
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(0, 0, -11 * ONE, ONE + 1),
                                1'b0, 1'b0});
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(0, 25 * ONE, 0, 31'h7fff_ffff),
                                1'b0, 1'b0});
      // normals outside unit length, used unnormalised
      directed_rows.push_back('{sft_pkg::CMD_LOAD, load_item(5, NORMAL_MIN, NORMAL_MIN,
                                                             NORMAL_MIN, COORD_MIN,
                                                             COORD_MIN, COORD_MIN),
                                1'b0, 1'b0});
      directed_rows.push_back('{sft_pkg::CMD_LOAD, load_item(4, NORMAL_MAX, NORMAL_MAX,
                                                             NORMAL_MAX, COORD_MAX,
                                                             COORD_MAX, COORD_MAX),
                                1'b0, 1'b0});
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(COORD_MAX, COORD_MAX, COORD_MAX,
                                                             31'h7fff_ffff), 1'b0, 1'b0});
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(COORD_MIN, COORD_MIN, COORD_MIN,
                                                             31'd0), 1'b0, 1'b0});
      directed_rows.push_back('{sft_pkg::CMD_TEST, test_item(0, 0, 0, 31'h7fff_ffff),
                                1'b0, 1'b0});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n])
         push_item(directed_rows[n].cmd, directed_rows[n].data, directed_rows[n].typed,
                   directed_rows[n].want);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         idling_on = (counted < RANDOM_ITEMS - CALM_TAIL);
         run_scene();
      end

      req_tvalid <= 1'b0;
      while (inside_due.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
